// ===== rtl/core/ibc_pkg.sv =====
// ----------------------------------------------------------------------------
// ibc_pkg: shared types and constants of the IMU bias calibrator
// Payload structs of both channels, register indexes, reset values and the
// fixed widths of the bias arithmetic.
// ----------------------------------------------------------------------------
package ibc_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_START    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_LENGTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_OFFSET = 3'd4;

	// Register reset values
	localparam logic [15:0] RST_CALIB_START    = 16'd100;
	localparam logic [15:0] RST_CALIB_LENGTH   = 16'd100;
	localparam logic [15:0] RST_ACCEL_GAIN     = 16'd642;
	localparam logic [15:0] RST_GYRO_GAIN      = 16'd249;
	localparam logic [22:0] RST_GRAVITY_OFFSET = 23'd642252;

	// Bias arithmetic
	localparam int NUM_AXES  = 6;
	localparam int AXIS_W    = 3;
	localparam int SUM_W     = 40;
	localparam int OUT_W     = 32;
	localparam int DIV_CNT_W = 6;

	// Axis order: accel x, y, z, gyro x, y, z
	localparam logic [AXIS_W-1:0] AX_ACCEL_X = 3'd0;
	localparam logic [AXIS_W-1:0] AX_ACCEL_Y = 3'd1;
	localparam logic [AXIS_W-1:0] AX_ACCEL_Z = 3'd2;
	localparam logic [AXIS_W-1:0] AX_GYRO_X  = 3'd3;
	localparam logic [AXIS_W-1:0] AX_GYRO_Y  = 3'd4;
	localparam logic [AXIS_W-1:0] AX_GYRO_Z  = 3'd5;

	typedef struct packed {
		logic [15:0] accel_x_raw;
		logic [15:0] accel_y_raw;
		logic [15:0] accel_z_raw;
		logic [15:0] gyro_x_raw;
		logic [15:0] gyro_y_raw;
		logic [15:0] gyro_z_raw;
	} ibc_in_t;

	typedef struct packed {
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
		logic signed [31:0] rate_x;
		logic signed [31:0] rate_y;
		logic signed [31:0] rate_z;
		logic               calibrating;
	} ibc_out_t;

endpackage

// ===== rtl/core/imu_bias_calibrator_unit.sv =====
// ----------------------------------------------------------------------------
// imu_bias_calibrator_unit: six-axis IMU scaling and bias removal
// Scales raw accelerometer and gyro words into Q16.16, averages the bias over
// a tick window and removes it afterwards, restoring gravity on z.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_ready carry one sample tick (six raw words) per transaction;
//   out_valid/out_ready return one result per tick, in order. cfg_wen writes
//   register cfg_idx with cfg_wdata at once; write only while the unit idles.
// Sequencing
//   One shared multiplier and one shared add/clamp unit walk the six axes:
//   from acceptance to out_valid a tick passes the window check, six
//   multiply and six accumulate/correct steps and the output load, which
//   waits for a free output register; the unit takes one tick at a time. When
//   the cached bias averages are out of date (after reset, after window ticks,
//   or after calib_length is written), the next non-window tick first has a
//   restoring divider recompute them, axis by axis (load, steps, store).
// Reset
//   arst_n clears the tick counter, the bias sums and the handshakes and
//   loads the register defaults. No clearing pass is needed.
// Stalls
//   A finished result waits in the output register; the next tick is still
//   accepted, and its result is held back until out_ready takes the first.
// ----------------------------------------------------------------------------
module imu_bias_calibrator_unit #(
	parameter int COUNT_WIDTH = 18
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_wen,
	input  logic [ibc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ibc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// sample input
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ibc_pkg::ibc_in_t                 in_data,
	// result output
	output logic                             out_valid,
	input  logic                             out_ready,
	output ibc_pkg::ibc_out_t                out_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WIN    = 3'd1;
	localparam logic [2:0] ST_DLOAD  = 3'd2;
	localparam logic [2:0] ST_DSTEP  = 3'd3;
	localparam logic [2:0] ST_DSTORE = 3'd4;
	localparam logic [2:0] ST_MUL    = 3'd5;
	localparam logic [2:0] ST_ACC    = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	localparam int SW = ibc_pkg::SUM_W;
	localparam int OW = ibc_pkg::OUT_W;
	localparam logic [ibc_pkg::DIV_CNT_W-1:0] DIV_LAST = ibc_pkg::DIV_CNT_W'(SW - 1);
	localparam logic [ibc_pkg::AXIS_W-1:0] AX_LAST = ibc_pkg::AX_GYRO_Z;

	// configuration registers
	logic [15:0] start_q;
	logic [15:0] len_q;
	logic [15:0] accel_gain_q;
	logic [15:0] gyro_gain_q;
	logic [22:0] grav_q;

	// sequencer and item state
	logic [2:0]                      state_q;
	logic [ibc_pkg::AXIS_W-1:0]      axis_q;
	logic [COUNT_WIDTH-1:0]          tick_q;
	logic                            calib_q;
	logic                            stale_q;
	ibc_pkg::ibc_in_t                in_q;
	logic signed [OW-1:0]            prod_q;
	logic signed [SW-1:0]            sum_q [ibc_pkg::NUM_AXES];
	logic signed [SW-1:0]            avg_q [ibc_pkg::NUM_AXES];
	logic signed [OW-1:0]            res_q [ibc_pkg::NUM_AXES];
	logic                            out_valid_q;
	ibc_pkg::ibc_out_t               out_q;

	// divider
	logic [SW-1:0]                   quo_q;
	logic [15:0]                     rem_q;
	logic                            neg_q;
	logic [ibc_pkg::DIV_CNT_W-1:0]   div_cnt_q;

	logic [16:0]                     win_end_w;
	logic                            calib_w;
	logic signed [15:0]              val_w;
	logic signed [16:0]              gain_w;
	logic signed [32:0]              prod_w;
	logic signed [SW-1:0]            sum_sel_w;
	logic signed [SW-1:0]            avg_sel_w;
	logic [SW:0]                     acc_w;
	logic [SW-1:0]                   acc_sat_w;
	logic [41:0]                     corr_w;
	logic [OW-1:0]                   corr_sat_w;
	logic [16:0]                     rem_sh_w;
	logic [17:0]                     trial_w;
	logic [SW-1:0]                   quo_next_w;
	logic [15:0]                     rem_next_w;
	logic [SW-1:0]                   avg_new_w;
	logic [SW-1:0]                   mag_w;
	logic                            out_free_w;

	// window check on the updated tick count
	always_comb begin
		win_end_w = {1'b0, start_q} + {1'b0, len_q};
		calib_w   = (tick_q > COUNT_WIDTH'(start_q)) && (tick_q <= COUNT_WIDTH'(win_end_w));
	end

	// select the raw axis value and its gain for the shared multiplier
	always_comb begin
		unique case (axis_q)
			ibc_pkg::AX_ACCEL_X: val_w = {{4{in_q.accel_x_raw[15]}}, in_q.accel_x_raw[15:4]};
			ibc_pkg::AX_ACCEL_Y: val_w = {{4{in_q.accel_y_raw[15]}}, in_q.accel_y_raw[15:4]};
			ibc_pkg::AX_ACCEL_Z: val_w = {{4{in_q.accel_z_raw[15]}}, in_q.accel_z_raw[15:4]};
			ibc_pkg::AX_GYRO_X:  val_w = in_q.gyro_x_raw;
			ibc_pkg::AX_GYRO_Y:  val_w = in_q.gyro_y_raw;
			default:             val_w = in_q.gyro_z_raw;
		endcase
		gain_w = (axis_q < ibc_pkg::AX_GYRO_X) ? {1'b0, accel_gain_q} : {1'b0, gyro_gain_q};
		prod_w = val_w * gain_w;
	end

	// accumulate with saturation, or correct and clamp to the output range
	always_comb begin
		sum_sel_w = sum_q[axis_q];
		avg_sel_w = avg_q[axis_q];
		acc_w     = {sum_sel_w[SW-1], sum_sel_w} + {{(SW+1-OW){prod_q[OW-1]}}, prod_q};
		if (acc_w[SW] != acc_w[SW-1]) begin
			acc_sat_w = acc_w[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			acc_sat_w = acc_w[SW-1:0];
		end
		corr_w = {{(42-OW){prod_q[OW-1]}}, prod_q} - {{(42-SW){avg_sel_w[SW-1]}}, avg_sel_w}
			+ ((axis_q == ibc_pkg::AX_ACCEL_Z) ? {19'd0, grav_q} : 42'd0);
		if ((corr_w[41:OW-1] == '0) || (corr_w[41:OW-1] == '1)) begin
			corr_sat_w = corr_w[OW-1:0];
		end else begin
			corr_sat_w = corr_w[41] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
		end
	end

	// restoring division step on magnitudes
	always_comb begin
		rem_sh_w   = {rem_q, quo_q[SW-1]};
		trial_w    = {1'b0, rem_sh_w} - {2'b00, len_q};
		quo_next_w = {quo_q[SW-2:0], !trial_w[17]};
		rem_next_w = trial_w[17] ? rem_sh_w[15:0] : trial_w[15:0];
		mag_w      = sum_sel_w[SW-1] ? (~sum_sel_w + 1'b1) : sum_sel_w;
		if (len_q == '0) begin
			avg_new_w = '0;
		end else begin
			avg_new_w = neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	assign out_free_w = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= ibc_pkg::RST_CALIB_START;
			len_q        <= ibc_pkg::RST_CALIB_LENGTH;
			accel_gain_q <= ibc_pkg::RST_ACCEL_GAIN;
			gyro_gain_q  <= ibc_pkg::RST_GYRO_GAIN;
			grav_q       <= ibc_pkg::RST_GRAVITY_OFFSET;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				ibc_pkg::REG_CALIB_START:    start_q      <= cfg_wdata[15:0];
				ibc_pkg::REG_CALIB_LENGTH:   len_q        <= cfg_wdata[15:0];
				ibc_pkg::REG_ACCEL_GAIN:     accel_gain_q <= cfg_wdata[15:0];
				ibc_pkg::REG_GYRO_GAIN:      gyro_gain_q  <= cfg_wdata[15:0];
				ibc_pkg::REG_GRAVITY_OFFSET: grav_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer with control state, bias sums and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			tick_q      <= '0;
			calib_q     <= 1'b0;
			stale_q     <= 1'b1;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ibc_pkg::NUM_AXES; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			// release the result once taken
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// a new divisor invalidates the cached averages
			if (cfg_wen && (cfg_idx == ibc_pkg::REG_CALIB_LENGTH)) begin
				stale_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (tick_q != '1) begin
							tick_q <= tick_q + 1'b1;
						end
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					calib_q <= calib_w;
					axis_q  <= '0;
					if (calib_w) begin
						stale_q <= 1'b1;
						state_q <= ST_MUL;
					end else if (stale_q) begin
						state_q <= ST_DLOAD;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DLOAD: begin
					div_cnt_q <= '0;
					state_q   <= ST_DSTEP;
				end
				ST_DSTEP: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_DSTORE;
					end
				end
				ST_DSTORE: begin
					if (axis_q == AX_LAST) begin
						axis_q  <= '0;
						stale_q <= 1'b0;
						state_q <= ST_MUL;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_DLOAD;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (calib_q) begin
						sum_q[axis_q] <= acc_sat_w;
					end
					if (axis_q == AX_LAST) begin
						state_q <= ST_OUT;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_free_w) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
		end
		if (state_q == ST_DLOAD) begin
			quo_q <= mag_w;
			rem_q <= '0;
			neg_q <= sum_sel_w[SW-1];
		end
		if (state_q == ST_DSTEP) begin
			quo_q <= quo_next_w;
			rem_q <= rem_next_w;
		end
		if (state_q == ST_DSTORE) begin
			avg_q[axis_q] <= avg_new_w;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_w[OW-1:0];
		end
		if (state_q == ST_ACC) begin
			res_q[axis_q] <= calib_q ? prod_q : corr_sat_w;
		end
		if ((state_q == ST_OUT) && out_free_w) begin
			out_q.accel_x     <= res_q[0];
			out_q.accel_y     <= res_q[1];
			out_q.accel_z     <= res_q[2];
			out_q.rate_x      <= res_q[3];
			out_q.rate_y      <= res_q[4];
			out_q.rate_z      <= res_q[5];
			out_q.calibrating <= calib_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/ibc_checker.sv =====
// ----------------------------------------------------------------------------
// ibc_checker: port-level checks of the IMU bias calibrator
// Watches both channels of the top level and flags handshake or sequencing
// slips; attached to every instance by the bind below.
// ----------------------------------------------------------------------------
module ibc_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              out_valid,
	input  logic              out_ready,
	input  ibc_pkg::ibc_out_t out_data
);

	// hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// drop ready after taking a tick: one tick at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second tick taken while one is in work");

	// a new result only appears from the busy sequencer
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared with no tick in work");

	// uncorrected accel x in the window stays within the 12-bit by 16-bit product
	a_calib_accel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.calibrating |->
			((out_data.accel_x[31:27] == 5'b00000) || (out_data.accel_x[31:27] == 5'b11111)))
		else $error("window accel result outside scaled range");

endmodule

bind imu_bias_calibrator_unit ibc_checker u_ibc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
